[design/signal_activity_table_unit_assert.svh]
// Assertion macros used by the checker file sat_checker.
`ifndef SIGNAL_ACTIVITY_TABLE_UNIT_ASSERT_SVH
`define SIGNAL_ACTIVITY_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SAT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sat assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sat assertion failed");

`endif

[design/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg
// Types, codes and entry update functions for the signal activity table.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int DEF_ENTRIES = 64;

   localparam logic [7:0] NO_CODE = 8'hFF;

   localparam int FL_OPEN  = 0;
   localparam int FL_BLACK = 1;
   localparam int FL_GOOD  = 2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [1:0] TONE_DCS   = 2'd1;
   localparam logic [1:0] TONE_CTCSS = 2'd2;

   typedef enum logic [2:0] {
      CMD_UPDATE,
      CMD_BLACK,
      CMD_GOOD,
      CMD_STANDBY,
      CMD_CLEAR,
      CMD_REMOVE,
      CMD_REPLACE,
      CMD_READ
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_FETCH,
      S_GRAB,
      S_APPLY,
      S_SWEEP,
      S_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [31:0] freq;
      logic [31:0] first_seen;
      logic [31:0] last_check;
      logic [31:0] last_open;
      logic [31:0] duration;
      logic [8:0]  rssi;
      logic [7:0]  ctcss;
      logic [7:0]  dcs;
      logic [2:0]  flags;
   } entry_type;

   function automatic entry_type new_entry(input logic [31:0] freq,
                                           input logic [31:0] now);
      entry_type e;
      e.freq       = freq;
      e.first_seen = now;
      e.last_check = now;
      e.last_open  = now;
      e.duration   = '0;
      e.rssi       = '0;
      e.ctcss      = NO_CODE;
      e.dcs        = NO_CODE;
      e.flags      = 3'b001;
      return e;
   endfunction

   function automatic entry_type upd_entry(input entry_type rec,
                                           input logic [31:0] now,
                                           input logic [8:0]  rssi,
                                           input logic        open,
                                           input logic        black,
                                           input logic [1:0]  kind,
                                           input logic [7:0]  code);
      entry_type e;
      logic      op;
      e  = rec;
      op = open && !rec.flags[FL_BLACK] && !rec.flags[FL_GOOD];
      e.rssi = rssi;
      if (rec.flags[FL_OPEN]) begin
         e.duration = rec.duration + (now - rec.last_check);
      end
      if (op) begin
         if (kind == TONE_DCS && code != NO_CODE) begin
            e.dcs = code;
         end
         if (kind == TONE_CTCSS && code != NO_CODE) begin
            e.ctcss = code;
         end
         e.last_open = now;
      end
      e.last_check      = now;
      e.flags[FL_OPEN]  = op;
      if (black) begin
         e.flags[FL_BLACK] = 1'b1;
      end
      return e;
   endfunction

   function automatic entry_type replace_entry(input entry_type rec,
                                               input logic [31:0] freq,
                                               input logic [31:0] now);
      entry_type e;
      e                = rec;
      e.freq           = freq;
      e.flags[FL_OPEN] = 1'b0;
      e.first_seen     = now;
      e.last_check     = now;
      e.last_open      = '0;
      e.duration       = '0;
      e.rssi           = '0;
      e.ctcss          = NO_CODE;
      e.dcs            = NO_CODE;
      return e;
   endfunction

endpackage

[design/sat_entry_ram.sv]
// ----------------------------------------------------------------------------
// sat_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sat_entry_ram #(
   parameter int DEPTH = sat_pkg::DEF_ENTRIES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  sat_pkg::entry_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output sat_pkg::entry_type rd_data
);
   import sat_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[design/signal_activity_table_unit.sv]
// ----------------------------------------------------------------------------
// signal_activity_table_unit
// Table of heard frequencies kept in one entry memory, walked by a sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | beat
//  req_    | in  | req_valid / req_stall  | command, frequency, time, measurement
//  rsp_    | out | rsp_valid / rsp_stall  | status, slot, count, entry fields
//
//  Update: one read per slot through the single memory read port, from slot 0
//  until a hit or the end of the table. Standby walks every entry; remove
//  shifts the entries above the index down by one slot.
//  Reset clears count, last-active state and the response valid; entries are
//  not cleared. A result waits in the output register while rsp_stall is high;
//  the next beat is taken only once the current one has reached that register.
module signal_activity_table_unit #(
   parameter int ENTRIES = sat_pkg::DEF_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_freq,
   input  logic [31:0] req_now_ms,
   input  logic [8:0]  req_meas_rssi,
   input  logic        req_meas_open,
   input  logic        req_meas_blacklist,
   input  logic [1:0]  req_tone_kind,
   input  logic [7:0]  req_tone_code,
   input  logic [5:0]  req_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot,
   output logic [6:0]  rsp_count_now,
   output logic [31:0] rsp_freq_out,
   output logic [31:0] rsp_duration_out,
   output logic [31:0] rsp_last_open_out,
   output logic [31:0] rsp_first_seen_out,
   output logic [8:0]  rsp_rssi_out,
   output logic [2:0]  rsp_flags_out,
   output logic [7:0]  rsp_ctcss_code_out,
   output logic [7:0]  rsp_dcs_code_out
);
   import sat_pkg::*;

   localparam int AW   = $clog2(ENTRIES);
   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int CMPW = CW + 6;

   state_type      state_ff, state_in;
   cmd_type        op_ff, op_in;
   logic [31:0]    freq_ff, freq_in;
   logic [31:0]    now_ff, now_in;
   logic [8:0]     rssi_ff, rssi_in;
   logic           open_ff, open_in;
   logic           black_ff, black_in;
   logic [1:0]     kind_ff, kind_in;
   logic [7:0]     code_ff, code_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  la_slot_ff, la_slot_in;
   logic           la_valid_ff, la_valid_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  pend_idx_ff, pend_idx_in;
   logic [AW-1:0]  slot_ff, slot_in;
   entry_type      rec_ff, rec_in;
   logic [1:0]     stat_ff, stat_in;
   logic           rep_ff, rep_in;

   logic           rsp_valid_ff;
   logic [1:0]     rsp_status_ff;
   logic [5:0]     rsp_slot_ff;
   logic [6:0]     rsp_count_ff;
   entry_type      rsp_rec_ff;

   logic           ram_we;
   logic [AW-1:0]  ram_wr_addr;
   entry_type      ram_wr_data;
   logic [AW-1:0]  ram_rd_addr;
   entry_type      ram_rd_data;

   entry_type      apply_rec;
   logic           accept, out_free, rsp_load;
   logic           ptr_lt, hit, srch_miss, walk_done;
   logic           la_ok, idx_ok, rm_more, can_append;

   sat_entry_ram #(
      .DEPTH (ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = (state_ff == S_RESP) && out_free;
   assign ptr_lt     = ptr_ff < count_ff;
   assign hit        = pend_ff && (ram_rd_data.freq == freq_ff);
   assign srch_miss  = !hit && !ptr_lt && !pend_ff;
   assign walk_done  = !ptr_lt && !pend_ff;
   assign la_ok      = la_valid_ff && (CW'(la_slot_ff) < count_ff);
   assign idx_ok     = CMPW'(req_index) < CMPW'(count_ff);
   assign rm_more    = (CW'(slot_ff) + CW'(1)) < count_ff;
   assign can_append = open_ff && (CMPW'(count_ff) < CMPW'(ENTRIES));

   always_comb begin
      apply_rec = rec_ff;
      case (op_ff)
         CMD_UPDATE: begin
            apply_rec = upd_entry(rec_ff, now_ff, rssi_ff, open_ff, black_ff,
                                  kind_ff, code_ff);
         end
         CMD_BLACK: begin
            apply_rec.flags = {1'b0, 1'b1, rec_ff.flags[FL_OPEN]};
         end
         CMD_GOOD: begin
            apply_rec.flags = {1'b1, 1'b0, rec_ff.flags[FL_OPEN]};
         end
         CMD_REPLACE: begin
            apply_rec = replace_entry(rec_ff, freq_ff, now_ff);
         end
         default: begin
            apply_rec = rec_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_cmd))
                  CMD_UPDATE:  state_in = S_SEARCH;
                  CMD_BLACK,
                  CMD_GOOD:    state_in = la_ok ? S_FETCH : S_RESP;
                  CMD_STANDBY: state_in = S_SWEEP;
                  CMD_REMOVE:  state_in = idx_ok ? S_SHIFT : S_RESP;
                  CMD_REPLACE,
                  CMD_READ:    state_in = idx_ok ? S_FETCH : S_RESP;
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               state_in = S_APPLY;
            end else if (srch_miss) begin
               state_in = can_append ? S_APPLY : S_RESP;
            end
         end
         S_FETCH: state_in = S_GRAB;
         S_GRAB:  state_in = S_APPLY;
         S_APPLY: state_in = S_RESP;
         S_SWEEP: begin
            if (walk_done) begin
               state_in = S_RESP;
            end
         end
         S_SHIFT: begin
            if (walk_done) begin
               state_in = rm_more ? S_FETCH : S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in       = op_ff;
      freq_in     = freq_ff;
      now_in      = now_ff;
      rssi_in     = rssi_ff;
      open_in     = open_ff;
      black_in    = black_ff;
      kind_in     = kind_ff;
      code_in     = code_ff;
      count_in    = count_ff;
      la_slot_in  = la_slot_ff;
      la_valid_in = la_valid_ff;
      ptr_in      = ptr_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      slot_in     = slot_ff;
      rec_in      = rec_ff;
      stat_in     = stat_ff;
      rep_in      = rep_ff;
      ram_we      = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = apply_rec;
      ram_rd_addr = slot_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = cmd_type'(req_cmd);
               freq_in  = req_freq;
               now_in   = req_now_ms;
               rssi_in  = req_meas_rssi;
               open_in  = req_meas_open;
               black_in = req_meas_blacklist;
               kind_in  = req_tone_kind;
               code_in  = req_tone_code;
               ptr_in   = '0;
               pend_in  = 1'b0;
               stat_in  = ST_OK;
               rep_in   = 1'b0;
               case (cmd_type'(req_cmd))
                  CMD_BLACK,
                  CMD_GOOD: begin
                     slot_in = la_slot_ff;
                     if (!la_ok) begin
                        stat_in = ST_NONE;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in    = '0;
                     la_valid_in = 1'b0;
                  end
                  CMD_REMOVE: begin
                     slot_in = AW'(req_index);
                     ptr_in  = CW'(req_index) + CW'(1);
                     if (!idx_ok) begin
                        stat_in = ST_NONE;
                     end
                  end
                  CMD_REPLACE,
                  CMD_READ: begin
                     slot_in = AW'(req_index);
                     if (!idx_ok) begin
                        stat_in = ST_NONE;
                     end
                  end
                  default: begin
                     stat_in = ST_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            ram_rd_addr = ptr_ff[AW-1:0];
            if (hit) begin
               rec_in  = ram_rd_data;
               slot_in = pend_idx_ff;
               pend_in = 1'b0;
            end else if (ptr_lt) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + CW'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (!open_ff) begin
               stat_in = ST_NONE;
            end else if (!can_append) begin
               stat_in = ST_FULL;
            end else begin
               rec_in   = new_entry(freq_ff, now_ff);
               slot_in  = count_ff[AW-1:0];
               count_in = count_ff + CW'(1);
            end
         end
         S_FETCH: begin
            ram_rd_addr = slot_ff;
         end
         S_GRAB: begin
            rec_in = ram_rd_data;
         end
         S_APPLY: begin
            rec_in = apply_rec;
            rep_in = 1'b1;
            ram_we = (op_ff != CMD_READ);
            if (op_ff == CMD_UPDATE && rec_ff.flags[FL_OPEN]) begin
               la_slot_in  = slot_ff;
               la_valid_in = 1'b1;
            end
         end
         S_SWEEP: begin
            ram_rd_addr = ptr_ff[AW-1:0];
            ram_wr_addr = pend_idx_ff;
            ram_wr_data = ram_rd_data;
            ram_wr_data.flags[FL_OPEN] = 1'b0;
            ram_wr_data.last_check     = now_ff;
            ram_we = pend_ff;
            if (ptr_lt) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         S_SHIFT: begin
            // move entry ptr down to ptr-1, one beat of the memory per cycle
            ram_rd_addr = ptr_ff[AW-1:0];
            ram_wr_addr = pend_idx_ff;
            ram_wr_data = ram_rd_data;
            ram_we      = pend_ff;
            if (ptr_lt) begin
               pend_in     = 1'b1;
               pend_idx_in = AW'(ptr_ff - CW'(1));
               ptr_in      = ptr_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (walk_done) begin
               count_in = count_ff - CW'(1);
               op_in    = CMD_READ;
            end
         end
         default: begin
            rep_in = rep_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         la_slot_ff  <= '0;
         la_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         la_slot_ff  <= la_slot_in;
         la_valid_ff <= la_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      freq_ff     <= freq_in;
      now_ff      <= now_in;
      rssi_ff     <= rssi_in;
      open_ff     <= open_in;
      black_ff    <= black_in;
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      ptr_ff      <= ptr_in;
      pend_ff     <= pend_in;
      pend_idx_ff <= pend_idx_in;
      slot_ff     <= slot_in;
      rec_ff      <= rec_in;
      stat_ff     <= stat_in;
      rep_ff      <= rep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the beat while stalled
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_count_ff  <= 7'(count_ff);
         rsp_slot_ff   <= rep_ff ? 6'(slot_ff) : 6'd0;
         rsp_rec_ff    <= rep_ff ? rec_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_count_now      = rsp_count_ff;
   assign rsp_freq_out       = rsp_rec_ff.freq;
   assign rsp_duration_out   = rsp_rec_ff.duration;
   assign rsp_last_open_out  = rsp_rec_ff.last_open;
   assign rsp_first_seen_out = rsp_rec_ff.first_seen;
   assign rsp_rssi_out       = rsp_rec_ff.rssi;
   assign rsp_flags_out      = rsp_rec_ff.flags;
   assign rsp_ctcss_code_out = rsp_rec_ff.ctcss;
   assign rsp_dcs_code_out   = rsp_rec_ff.dcs;

endmodule

[design/sat_checker.sv]
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks on the signal activity table, bound to the top level.
// ----------------------------------------------------------------------------
`include "signal_activity_table_unit_assert.svh"

module sat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [5:0]  rsp_slot,
   input logic [6:0]  rsp_count_now,
   input logic [31:0] rsp_freq_out,
   input logic [2:0]  rsp_flags_out
);
   import sat_pkg::*;

   logic        stalled_beat;
   logic        rsp_fail;
   logic        fail_zero;
   logic [14:0] rsp_head;

   assign stalled_beat = rsp_valid && rsp_stall;
   assign rsp_fail     = rsp_valid && (rsp_status != ST_OK);
   assign fail_zero    = (rsp_slot == '0) && (rsp_freq_out == '0) && (rsp_flags_out == '0);
   assign rsp_head     = {rsp_status, rsp_slot, rsp_count_now};

   `SAT_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && !req_stall, req_stall)
   `SAT_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status <= ST_FULL)
   `SAT_ASSERT_IMPLY(a_fail_is_empty, clock, reset, rsp_fail, fail_zero)
   `SAT_ASSERT_NEXT(a_stall_holds, clock, reset, stalled_beat, rsp_valid && $stable(rsp_head))

endmodule

bind signal_activity_table_unit sat_checker u_sat_checker (.*);

[test/tb_signal_activity_table_unit.sv]
// ----------------------------------------------------------------------------
// tb_signal_activity_table_unit
// Drives commands into the activity table, predicts every response with a
// scoreboard-side copy of the table and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_signal_activity_table_unit;
   import sat_pkg::*;

   localparam int N_SLOTS = DEF_ENTRIES;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] freq;
      logic [31:0] now;
      logic [8:0]  rssi;
      logic        open_m;
      logic        black;
      logic [1:0]  kind;
      logic [7:0]  code;
      logic [5:0]  idx;
      int          mode;
      bit          hold;
   } beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot;
      logic [6:0]  count;
      logic [31:0] freq;
      logic [31:0] dur;
      logic [31:0] lopen;
      logic [31:0] first;
      logic [8:0]  rssi;
      logic [2:0]  flags;
      logic [7:0]  ctcss;
      logic [7:0]  dcs;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic [31:0] req_freq = '0;
   logic [31:0] req_now_ms = '0;
   logic [8:0]  req_meas_rssi = '0;
   logic        req_meas_open = 1'b0;
   logic        req_meas_blacklist = 1'b0;
   logic [1:0]  req_tone_kind = '0;
   logic [7:0]  req_tone_code = '0;
   logic [5:0]  req_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_slot;
   logic [6:0]  rsp_count_now;
   logic [31:0] rsp_freq_out;
   logic [31:0] rsp_duration_out;
   logic [31:0] rsp_last_open_out;
   logic [31:0] rsp_first_seen_out;
   logic [8:0]  rsp_rssi_out;
   logic [2:0]  rsp_flags_out;
   logic [7:0]  rsp_ctcss_code_out;
   logic [7:0]  rsp_dcs_code_out;

   signal_activity_table_unit dut (.*);

   // table copy
   entry_type  shadow [N_SLOTS];
   int         n_entries = 0;
   int         last_slot = 0;
   bit         last_ok = 1'b0;

   beat_type   pending [$];
   answer_type expected [$];
   beat_type   cur;
   int         cur_mode = 0;
   bit         took = 1'b0;
   int         errors = 0;
   int         n_beats = 0;
   int         n_answers = 0;
   int         n_full = 0;
   logic [31:0] clock_ms = 32'hFFFF_F000;
   logic [31:0] freq_pool [80];

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic answer_type entry_view(logic [1:0] st, int s);
      answer_type o;
      o = '0;
      o.status = st;
      o.count  = n_entries[6:0];
      if (st == ST_OK && s < n_entries) begin
         o.slot  = s[5:0];
         o.freq  = shadow[s].freq;
         o.dur   = shadow[s].duration;
         o.lopen = shadow[s].last_open;
         o.first = shadow[s].first_seen;
         o.rssi  = shadow[s].rssi;
         o.flags = shadow[s].flags;
         o.ctcss = shadow[s].ctcss;
         o.dcs   = shadow[s].dcs;
      end
      return o;
   endfunction

   function automatic answer_type table_step(beat_type b);
      int  s;
      bit  op;
      s = n_entries;
      case (b.cmd)
         CMD_UPDATE: begin
            for (int i = 0; i < n_entries; i++) begin
               if (shadow[i].freq == b.freq) begin
                  s = i;
                  break;
               end
            end
            if (s >= n_entries) begin
               if (!b.open_m) return entry_view(ST_NONE, 0);
               if (n_entries >= N_SLOTS) return entry_view(ST_FULL, 0);
               shadow[s].freq       = b.freq;
               shadow[s].first_seen = b.now;
               shadow[s].last_check = b.now;
               shadow[s].last_open  = b.now;
               shadow[s].duration   = '0;
               shadow[s].rssi       = '0;
               shadow[s].flags      = 3'b001;
               shadow[s].ctcss      = NO_CODE;
               shadow[s].dcs        = NO_CODE;
               n_entries++;
            end
            op = b.open_m && !shadow[s].flags[FL_BLACK] && !shadow[s].flags[FL_GOOD];
            shadow[s].rssi = b.rssi;
            if (shadow[s].flags[FL_OPEN]) begin
               shadow[s].duration += b.now - shadow[s].last_check;
               last_slot = s;
               last_ok   = 1'b1;
            end
            if (op) begin
               if (b.kind == TONE_DCS && b.code != NO_CODE) shadow[s].dcs = b.code;
               if (b.kind == TONE_CTCSS && b.code != NO_CODE) shadow[s].ctcss = b.code;
               shadow[s].last_open = b.now;
            end
            shadow[s].last_check     = b.now;
            shadow[s].flags[FL_OPEN] = op;
            if (b.black) shadow[s].flags[FL_BLACK] = 1'b1;
            return entry_view(ST_OK, s);
         end
         CMD_BLACK, CMD_GOOD: begin
            if (!last_ok || last_slot >= n_entries) return entry_view(ST_NONE, 0);
            shadow[last_slot].flags[FL_BLACK] = (b.cmd == CMD_BLACK);
            shadow[last_slot].flags[FL_GOOD]  = (b.cmd == CMD_GOOD);
            return entry_view(ST_OK, last_slot);
         end
         CMD_STANDBY: begin
            for (int i = 0; i < n_entries; i++) begin
               shadow[i].flags[FL_OPEN] = 1'b0;
               shadow[i].last_check     = b.now;
            end
            return entry_view(ST_OK, n_entries);
         end
         CMD_CLEAR: begin
            n_entries = 0;
            last_ok   = 1'b0;
            return entry_view(ST_OK, 0);
         end
         CMD_REMOVE: begin
            if (b.idx >= n_entries) return entry_view(ST_NONE, 0);
            for (int i = b.idx; i + 1 < n_entries; i++) shadow[i] = shadow[i + 1];
            n_entries--;
            return entry_view(ST_OK, b.idx);
         end
         CMD_REPLACE: begin
            if (b.idx >= n_entries) return entry_view(ST_NONE, 0);
            shadow[b.idx].freq           = b.freq;
            shadow[b.idx].flags[FL_OPEN] = 1'b0;
            shadow[b.idx].first_seen     = b.now;
            shadow[b.idx].last_check     = b.now;
            shadow[b.idx].last_open      = '0;
            shadow[b.idx].duration       = '0;
            shadow[b.idx].rssi           = '0;
            shadow[b.idx].ctcss          = NO_CODE;
            shadow[b.idx].dcs            = NO_CODE;
            return entry_view(ST_OK, b.idx);
         end
         default: begin
            if (b.idx >= n_entries) return entry_view(ST_NONE, 0);
            return entry_view(ST_OK, b.idx);
         end
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic add_beat(cmd_type c, logic [31:0] f, bit op, bit bl, logic [1:0] k,
                           logic [7:0] cd, logic [5:0] ix, logic [8:0] rs, int md, bit hd);
      beat_type b;
      if ($urandom_range(0, 199) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, 3000);
      b.cmd = c; b.freq = f; b.now = clock_ms; b.rssi = rs; b.open_m = op;
      b.black = bl; b.kind = k; b.code = cd; b.idx = ix; b.mode = md; b.hold = hd;
      pending.push_back(b);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || took) begin
            if (pending.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending[0].hold && expected.size() != 0) begin
               req_valid <= 1'b0;
            end else if ((cur_mode == 1 && $urandom_range(0, 99) < 75) ||
                         (cur_mode == 3 && $urandom_range(0, 99) < 7)) begin
               req_valid <= 1'b0;
            end else begin
               cur = pending.pop_front();
               cur_mode           = cur.mode;
               req_valid          <= 1'b1;
               req_cmd            <= cur.cmd;
               req_freq           <= cur.freq;
               req_now_ms         <= cur.now;
               req_meas_rssi      <= cur.rssi;
               req_meas_open      <= cur.open_m;
               req_meas_blacklist <= cur.black;
               req_tone_kind      <= cur.kind;
               req_tone_code      <= cur.code;
               req_index          <= cur.idx;
            end
         end
         rsp_stall <= (cur_mode == 2 && $urandom_range(0, 99) < 75) ||
                      (cur_mode == 3 && $urandom_range(0, 99) < 7);
      end
   end

   // monitor
   always @(posedge clock) begin
      answer_type want;
      took = !reset && req_valid && !req_stall;
      if (took) begin
         want = table_step(cur);
         if (want.status == ST_FULL) n_full++;
         expected.push_back(want);
         n_beats++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         n_answers++;
         if (expected.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            errors++;
         end else begin
            want = expected.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("slot", want.slot, rsp_slot);
            check_field("count_now", want.count, rsp_count_now);
            check_field("freq_out", want.freq, rsp_freq_out);
            check_field("duration_out", want.dur, rsp_duration_out);
            check_field("last_open_out", want.lopen, rsp_last_open_out);
            check_field("first_seen_out", want.first, rsp_first_seen_out);
            check_field("rssi_out", want.rssi, rsp_rssi_out);
            check_field("flags_out", want.flags, rsp_flags_out);
            check_field("ctcss_code_out", want.ctcss, rsp_ctcss_code_out);
            check_field("dcs_code_out", want.dcs, rsp_dcs_code_out);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("tb_signal_activity_table_unit: errors");
      $finish;
   end

   initial begin
      int r;
      cmd_type c;
      for (int i = 0; i < 80; i++) freq_pool[i] = $urandom;
      // directed
      add_beat(CMD_BLACK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(CMD_UPDATE, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(CMD_UPDATE, 32'h0, 1, 0, TONE_DCS, 8'h00, 0, 9'h1FF, 0, 0);
      add_beat(CMD_UPDATE, 32'hFFFF_FFFF, 1, 0, TONE_CTCSS, 8'hFE, 63, 0, 0, 0);
      add_beat(CMD_UPDATE, 32'h0, 1, 0, TONE_CTCSS, NO_CODE, 0, 9'h0AA, 0, 0);
      add_beat(CMD_UPDATE, 32'h0, 1, 0, 2'd3, 8'h55, 0, 9'h155, 0, 0);
      add_beat(CMD_UPDATE, 32'hFFFF_FFFF, 1, 0, TONE_DCS, NO_CODE, 0, 3, 0, 0);
      add_beat(CMD_BLACK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(CMD_UPDATE, 32'hFFFF_FFFF, 1, 0, TONE_DCS, 8'h12, 0, 5, 0, 0);
      add_beat(CMD_UPDATE, 32'h0, 0, 1, 0, 0, 0, 7, 0, 0);
      add_beat(CMD_GOOD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(CMD_UPDATE, 32'h1234_5678, 1, 1, TONE_CTCSS, 8'h33, 0, 9, 0, 0);
      add_beat(CMD_STANDBY, 0, 1, 1, 3, 8'hFF, 63, 9'h1FF, 0, 0);
      add_beat(CMD_READ, 0, 0, 0, 0, 0, 2, 0, 0, 0);
      add_beat(CMD_READ, 0, 0, 0, 0, 0, 63, 0, 0, 0);
      add_beat(CMD_REPLACE, 32'hAAAA_5555, 0, 0, 0, 0, 1, 0, 0, 0);
      add_beat(CMD_REPLACE, 32'h5555_AAAA, 0, 0, 0, 0, 63, 0, 0, 0);
      add_beat(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(CMD_REMOVE, 0, 0, 0, 0, 0, 40, 0, 0, 0);
      add_beat(CMD_REMOVE, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_beat(CMD_GOOD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // random, one phase per idling style, each starting from a drained pipe
      for (int ph = 0; ph < 4; ph++) begin
         for (int n = 0; n < 345; n++) begin
            r = $urandom_range(0, 99);
            c = r < 62 ? CMD_UPDATE : r < 67 ? CMD_BLACK : r < 72 ? CMD_GOOD :
                r < 76 ? CMD_STANDBY : r < 77 ? CMD_CLEAR : r < 85 ? CMD_REMOVE :
                r < 90 ? CMD_REPLACE : CMD_READ;
            add_beat(c,
                     $urandom_range(0, 99) < 85 ? freq_pool[$urandom_range(0, 79)] : $urandom,
                     $urandom_range(0, 99) < 70, $urandom_range(0, 99) < 5,
                     2'($urandom_range(0, 3)),
                     $urandom_range(0, 99) < 20 ? NO_CODE : 8'($urandom),
                     $urandom_range(0, 99) < 70 ? 6'($urandom_range(0, 15)) :
                                                  6'($urandom_range(0, 63)),
                     9'($urandom), ph, n == 0);
         end
      end
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (pending.size() != 0 || req_valid || expected.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (expected.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected.size());
         errors++;
      end
      $display("covered %0d command beats, %0d responses checked, %0d table-full answers",
               n_beats, n_answers, n_full);
      if (errors == 0) begin
         $display("tb_signal_activity_table_unit: clean");
      end else begin
         $display("tb_signal_activity_table_unit: errors");
      end
      $finish;
   end

endmodule
